[design/rbs_pkg.sv]
// shared types and constants for the record byte scrubber
package rbs_pkg;

  localparam logic [7:0] VALID_LOW   = 8'd32;
  localparam logic [7:0] VALID_HIGH  = 8'd126;
  localparam logic [7:0] EOR_MARK    = 8'd250;
  localparam logic [7:0] EOR_NEWLINE = 8'd10;
  localparam logic [7:0] WIPE_VALUE  = 8'd255;

  localparam logic [1:0] MODE_POSITION = 2'd0;
  localparam logic [1:0] MODE_FULL     = 2'd1;
  localparam logic [1:0] MODE_ZERO     = 2'd2;
  localparam logic [1:0] MODE_BOTH     = 2'd3;
  localparam int unsigned MODE_FULL_BIT = 0;
  localparam int unsigned MODE_ZERO_BIT = 1;

  localparam logic [15:0] IDX_MAX   = 16'hFFFF;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_RECORD_LENGTH  = 2'd0,
    CFG_FILL_CHAR      = 2'd1,
    CFG_ZERO_THRESHOLD = 2'd2,
    CFG_CLEAN_MODE     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] record_length;
    logic [6:0]  fill_char;
    logic [15:0] zero_threshold;
    logic [1:0]  clean_mode;
  } cfg_t;

  typedef struct packed {
    logic [15:0] byte_index;
    logic [15:0] zero_count;
    logic        changed;
    logic [31:0] total;
  } state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        was_replaced;
    logic        last_of_record;
    logic        wipe_record;
    logic        record_changed;
    logic [15:0] record_zero_count;
    logic [31:0] total_replaced;
  } result_t;

endpackage

[design/rbs_core.sv]
// per-byte replacement rule and record bookkeeping
module rbs_core (
  input  logic [7:0]      data_byte,
  input  rbs_pkg::cfg_t   cfg,
  input  rbs_pkg::state_t st,
  output rbs_pkg::state_t st_nxt,
  output rbs_pkg::result_t res
);

  logic        last;
  logic        out_of_range;
  logic        marker;
  logic        invalid;
  logic        replaced;
  logic        zero_hit;
  logic        wipe;
  logic        changed_new;
  logic [7:0]  ob;
  logic [15:0] zc_new;
  logic [31:0] total_new;
  logic [16:0] idx_plus;

  assign idx_plus     = {1'b0, st.byte_index} + 17'd1;
  assign last         = idx_plus >= {1'b0, cfg.record_length};
  assign out_of_range = (data_byte < rbs_pkg::VALID_LOW) || (data_byte > rbs_pkg::VALID_HIGH);
  assign marker       = (data_byte == rbs_pkg::EOR_MARK) || (data_byte == rbs_pkg::EOR_NEWLINE);
  assign invalid      = out_of_range && !(marker && last);

  always_comb begin
    ob       = data_byte;
    replaced = 1'b0;
    zero_hit = 1'b0;
    if (invalid) begin
      if (cfg.clean_mode == rbs_pkg::MODE_POSITION) begin
        ob       = {1'b0, cfg.fill_char};
        replaced = 1'b1;
      end else if (data_byte == 8'd0) begin
        if (cfg.clean_mode[rbs_pkg::MODE_ZERO_BIT]) begin
          ob       = rbs_pkg::WIPE_VALUE;
          replaced = 1'b1;
          zero_hit = 1'b1;
        end
      end else if (cfg.clean_mode[rbs_pkg::MODE_FULL_BIT]) begin
        ob       = {1'b0, cfg.fill_char};
        replaced = 1'b1;
      end
    end
  end

  assign zc_new      = (zero_hit && st.zero_count != rbs_pkg::IDX_MAX) ?
                       st.zero_count + 16'd1 : st.zero_count;
  assign total_new   = (replaced && st.total != rbs_pkg::TOTAL_MAX) ?
                       st.total + 32'd1 : st.total;
  assign changed_new = st.changed | replaced;
  assign wipe        = last && cfg.clean_mode[rbs_pkg::MODE_ZERO_BIT] &&
                       (zc_new > cfg.zero_threshold);

  always_comb begin
    res.out_byte          = wipe ? rbs_pkg::WIPE_VALUE : ob;
    res.was_replaced      = replaced;
    res.last_of_record    = last;
    res.wipe_record       = wipe;
    res.record_changed    = last && (changed_new || wipe);
    res.record_zero_count = zc_new;
    res.total_replaced    = total_new;
  end

  always_comb begin
    st_nxt.total = total_new;
    if (last) begin
      st_nxt.byte_index = 16'd0;
      st_nxt.zero_count = 16'd0;
      st_nxt.changed    = 1'b0;
    end else begin
      st_nxt.byte_index = (st.byte_index != rbs_pkg::IDX_MAX) ?
                          st.byte_index + 16'd1 : st.byte_index;
      st_nxt.zero_count = zc_new;
      st_nxt.changed    = changed_new;
    end
  end

endmodule

[design/record_byte_scrubber_top.sv]
// top level of the record byte scrubber: config registers, pipeline and stream ports
//
// One result per input byte. A byte is taken in every cycle the output side keeps up;
// it is held in an input register, classified and counted by the combinational core,
// and lands in the result register, from which it is presented on the output port.
// The rate of one byte per cycle while the output is not stalled rests on the update of
// the record position, zero count and running total as each byte advances.
// There is no clearing pass after reset.
// Config writes must only be issued while the block is empty.
module record_byte_scrubber_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte[7:0], was_replaced[8], wipe_record[9], record_changed[10],
  // record_zero_count[26:11], total_replaced[58:27], zero pad[63:59]
  output logic [63:0] out_tdata,
  output logic        out_tlast   // last_of_record
);

  rbs_pkg::cfg_t    cfg_r;
  rbs_pkg::state_t  st_r;
  rbs_pkg::state_t  st_nxt;
  rbs_pkg::result_t res_nxt;
  rbs_pkg::result_t res_r;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_accept;
  logic       adv;

  assign adv          = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || adv;
  assign in_accept    = in_tvalid && in_tready;
  assign s1_valid_nxt = in_accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_length  <= 16'd1;
      cfg_r.fill_char      <= 7'd32;
      cfg_r.zero_threshold <= 16'd10;
      cfg_r.clean_mode     <= rbs_pkg::MODE_POSITION;
    end else if (cfg_we) begin
      unique case (rbs_pkg::cfg_idx_t'(cfg_addr))
        rbs_pkg::CFG_RECORD_LENGTH:  cfg_r.record_length  <= cfg_wdata;
        rbs_pkg::CFG_FILL_CHAR:      cfg_r.fill_char      <= cfg_wdata[6:0];
        rbs_pkg::CFG_ZERO_THRESHOLD: cfg_r.zero_threshold <= cfg_wdata;
        rbs_pkg::CFG_CLEAN_MODE:     cfg_r.clean_mode     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  rbs_core u_core (
    .data_byte (s1_byte_r),
    .cfg       (cfg_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_tdata;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.last_of_record;
  assign out_tdata  = {5'd0, res_r.total_replaced, res_r.record_zero_count,
                       res_r.record_changed, res_r.wipe_record, res_r.was_replaced,
                       res_r.out_byte};

  // a wipe only ever ends a record and always shows the wipe value
  a_wipe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.wipe_record |-> res_r.last_of_record &&
    res_r.out_byte == rbs_pkg::WIPE_VALUE && res_r.record_changed)
    else $error("wipe outside last byte or wrong value");

  // record change is only reported at the end of a record
  a_changed_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.record_changed |-> res_r.last_of_record)
    else $error("record change flagged mid-record");

  // running total never goes backward
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> st_r.total >= $past(st_r.total))
    else $error("replacement total decreased");

  // position and counters are cleared after the last byte of a record
  a_record_reset: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.last_of_record |=> st_r.byte_index == 16'd0 &&
    st_r.zero_count == 16'd0 && !st_r.changed)
    else $error("record state not cleared");

endmodule

[dv/record_byte_scrubber_top_tb.sv]
// self-checking testbench for the record byte scrubber top level
module record_byte_scrubber_top_tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;

  // scrubber model state and its copy of the registers
  logic [15:0] rec_len;
  logic [6:0]  fill_val;
  logic [15:0] zero_limit;
  logic [1:0]  mode_sel;
  logic [15:0] pos_idx;
  logic [15:0] zero_run;
  logic        rec_dirty;
  logic [31:0] repl_total;

  rbs_pkg::result_t scrubbed_q[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  bit      gaps_on = 1'b1;
  bit      stalls_on = 1'b1;
  int      ready_hold = 0;

  record_byte_scrubber_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output backpressure: short and long stalls, or none
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
      ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  function automatic rbs_pkg::result_t scrub_byte(input logic [7:0] b);
    rbs_pkg::result_t r;
    logic last, out_of_range, marker, invalid, repl, wipe;
    logic [7:0] ob;
    last = ({1'b0, pos_idx} + 17'd1) >= {1'b0, rec_len};
    out_of_range = (b < rbs_pkg::VALID_LOW) || (b > rbs_pkg::VALID_HIGH);
    marker = (b == rbs_pkg::EOR_MARK) || (b == rbs_pkg::EOR_NEWLINE);
    invalid = out_of_range && !(marker && last);
    ob = b;
    repl = 1'b0;
    wipe = 1'b0;
    if (invalid) begin
      if (mode_sel == rbs_pkg::MODE_POSITION) begin
        ob = {1'b0, fill_val};
        repl = 1'b1;
      end else if (b == 8'd0) begin
        if (mode_sel[rbs_pkg::MODE_ZERO_BIT]) begin
          ob = rbs_pkg::WIPE_VALUE;
          repl = 1'b1;
          if (zero_run != rbs_pkg::IDX_MAX) zero_run = zero_run + 16'd1;
        end
      end else if (mode_sel[rbs_pkg::MODE_FULL_BIT]) begin
        ob = {1'b0, fill_val};
        repl = 1'b1;
      end
    end
    if (repl) begin
      rec_dirty = 1'b1;
      if (repl_total != rbs_pkg::TOTAL_MAX) repl_total = repl_total + 32'd1;
    end
    r.record_zero_count = zero_run;
    r.record_changed = 1'b0;
    if (last) begin
      wipe = mode_sel[rbs_pkg::MODE_ZERO_BIT] && (zero_run > zero_limit);
      if (wipe) ob = rbs_pkg::WIPE_VALUE;
      r.record_changed = rec_dirty | wipe;
      pos_idx = '0;
      zero_run = '0;
      rec_dirty = 1'b0;
    end else if (pos_idx != rbs_pkg::IDX_MAX) begin
      pos_idx = pos_idx + 16'd1;
    end
    r.out_byte = ob;
    r.was_replaced = repl;
    r.last_of_record = last;
    r.wipe_record = wipe;
    r.total_replaced = repl_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    rbs_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (scrubbed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = scrubbed_q.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(out_tdata[7:0]));
        check_field("was_replaced", 32'(want.was_replaced), 32'(out_tdata[8]));
        check_field("last_of_record", 32'(want.last_of_record), 32'(out_tlast));
        check_field("wipe_record", 32'(want.wipe_record), 32'(out_tdata[9]));
        check_field("record_changed", 32'(want.record_changed), 32'(out_tdata[10]));
        check_field("record_zero_count", 32'(want.record_zero_count),
                    32'(out_tdata[26:11]));
        check_field("total_replaced", want.total_replaced, out_tdata[58:27]);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap, r;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scrubbed_q.push_back(scrub_byte(b));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (scrubbed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rbs_pkg::cfg_idx_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      rbs_pkg::CFG_RECORD_LENGTH:  rec_len = value;
      rbs_pkg::CFG_FILL_CHAR:      fill_val = value[6:0];
      rbs_pkg::CFG_ZERO_THRESHOLD: zero_limit = value;
      rbs_pkg::CFG_CLEAN_MODE:     mode_sel = value[1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] len, input logic [15:0] fill,
                             input logic [15:0] thr, input logic [1:0] mode);
    wait_idle();
    write_reg(rbs_pkg::CFG_RECORD_LENGTH, len);
    write_reg(rbs_pkg::CFG_FILL_CHAR, fill);
    write_reg(rbs_pkg::CFG_ZERO_THRESHOLD, thr);
    write_reg(rbs_pkg::CFG_CLEAN_MODE, {14'd0, mode});
    cfg_we <= 1'b0;
  endtask

  // register defaults: single-byte records, markers always exempt
  task automatic test_reset_values();
    send_byte(8'd0);
    send_byte(8'd31);
    send_byte(8'd32);
    send_byte(8'd126);
    send_byte(8'd127);
    send_byte(8'd255);
    send_byte(rbs_pkg::EOR_NEWLINE);
    send_byte(rbs_pkg::EOR_MARK);
  endtask

  task automatic test_modes();
    for (int m = 0; m < 4; m++) begin
      load_config(16'd4, 16'd35, 16'd1, m[1:0]);
      send_byte(8'd0);
      send_byte(rbs_pkg::EOR_MARK);
      send_byte(8'd0);
      send_byte(rbs_pkg::EOR_NEWLINE);
    end
  endtask

  task automatic test_special_cases();
    // zero length, fill from masked write
    load_config(16'd0, 16'hFF80, 16'hFFFF, rbs_pkg::MODE_FULL);
    send_byte(8'd200);
    send_byte(8'd5);
    // length lowered mid-record
    load_config(16'd6, 16'd127, 16'd0, rbs_pkg::MODE_BOTH);
    send_byte(8'd65);
    send_byte(8'd66);
    send_byte(8'd67);
    load_config(16'd2, 16'd127, 16'd0, rbs_pkg::MODE_BOTH);
    send_byte(8'd0);
    // mode switched mid-record, wipe uses mode at last byte
    load_config(16'd4, 16'd33, 16'd0, rbs_pkg::MODE_POSITION);
    send_byte(8'd0);
    load_config(16'd4, 16'd33, 16'd0, rbs_pkg::MODE_ZERO);
    send_byte(8'd0);
    send_byte(8'd65);
    send_byte(8'd66);
  endtask

  // long record of zeros sent back to back: zero count climbs past the threshold
  task automatic test_long_record();
    load_config(16'd150, 16'd32, 16'd100, rbs_pkg::MODE_BOTH);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (150) send_byte(8'd0);
    wait_idle();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random();
    int sent, n, r;
    logic [15:0] len, thr;
    logic [7:0] b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) len = 16'd0;
      else if (r == 1) len = 16'd1;
      else if (r == 2) len = 16'd2;
      else if (r == 8) len = 16'($urandom_range(17, 300));
      else if (r == 9) len = 16'hFFFF;
      else len = 16'($urandom_range(3, 16));
      r = $urandom_range(0, 9);
      if (r == 0) thr = 16'd0;
      else if (r == 1) thr = 16'hFFFF;
      else thr = 16'($urandom_range(0, 6));
      load_config(len, 16'($urandom_range(0, 65535)), thr, 2'($urandom_range(0, 3)));
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(60, 140);
      repeat (n) begin
        if ((({1'b0, pos_idx} + 17'd1) >= {1'b0, rec_len}) && $urandom_range(0, 1)) begin
          b = $urandom_range(0, 1) ? rbs_pkg::EOR_MARK : rbs_pkg::EOR_NEWLINE;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: b = 8'($urandom_range(32, 126));
            4, 5:       b = 8'd0;
            6:          b = $urandom_range(0, 1) ? rbs_pkg::EOR_MARK : rbs_pkg::EOR_NEWLINE;
            default:    b = 8'($urandom_range(0, 255));
          endcase
        end
        send_byte(b);
      end
      sent += n;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    rec_len = 16'd1;
    fill_val = 7'd32;
    zero_limit = 16'd10;
    mode_sel = rbs_pkg::MODE_POSITION;
    pos_idx = '0;
    zero_run = '0;
    rec_dirty = 1'b0;
    repl_total = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_modes();
    test_special_cases();
    test_long_record();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
design/rbs_pkg.sv
design/rbs_core.sv
design/record_byte_scrubber_top.sv
dv/record_byte_scrubber_top_tb.sv
